[rtl/str_pkg.sv]
`default_nettype none

package str_pkg;

  // Field widths
  localparam int TENSOR_WIDTH = 32;
  localparam int COEF_WIDTH   = 16;
  localparam int COEF_FRAC    = COEF_WIDTH - 2;
  localparam int SHIFT_BITS   = 2 * COEF_FRAC;

  // One product of two coefficients, and the sum of two such products
  localparam int CSUM_W = 2 * COEF_WIDTH + 1;
  // Shared multiplier operand width covers both tensor and coefficient sums
  localparam int MUL_W  = (TENSOR_WIDTH > CSUM_W) ? TENSOR_WIDTH : CSUM_W;
  localparam int PROD_W = 2 * MUL_W;
  // Six exact products summed
  localparam int ACC_W  = PROD_W + 3;

  localparam int NUM_COMP  = 6;
  localparam int MAT_DIM   = 3;
  localparam int MAT_DEPTH = MAT_DIM * MAT_DIM;
  localparam int ADDR_W    = 4;
  localparam int IDX_W     = 3;
  localparam int ROW_W     = 2;
  localparam int OP_W      = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ROTATE = 2'd1;
  localparam logic [OP_W-1:0] OP_PASS   = 2'd2;

  localparam logic [ROW_W-1:0] ROW_LAST = 2'd2;
  localparam logic [IDX_W-1:0] IDX_LAST = 3'd5;
  localparam logic [IDX_W-1:0] IDX_OFFD = 3'd3;

  typedef logic signed [TENSOR_WIDTH-1:0] tensor_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic signed [CSUM_W-1:0]       csum_t;
  typedef logic signed [MUL_W-1:0]        mul_opnd_t;
  typedef logic signed [PROD_W-1:0]       prod_t;
  typedef logic signed [ACC_W-1:0]        acc_t;
  typedef logic [ADDR_W-1:0]              addr_t;

  // Coefficient store port controls
  typedef struct packed {
    logic  we;
    addr_t waddr;
    coef_t wdata;
    addr_t raddr0;
    addr_t raddr1;
  } ram_ctl_t;

  // Component index -> first axis (xx yy zz xy yz zx)
  function automatic logic [ROW_W-1:0] pair_a(input logic [IDX_W-1:0] idx);
    logic [ROW_W-1:0] r;
    case (idx)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd0;
      3'd4:    r = 2'd1;
      3'd5:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // Component index -> second axis
  function automatic logic [ROW_W-1:0] pair_b(input logic [IDX_W-1:0] idx);
    logic [ROW_W-1:0] r;
    case (idx)
      3'd0:    r = 2'd0;
      3'd1:    r = 2'd1;
      3'd2:    r = 2'd2;
      3'd3:    r = 2'd1;
      3'd4:    r = 2'd2;
      3'd5:    r = 2'd0;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

  // Row-major matrix address
  function automatic addr_t mat_addr(input logic [ROW_W-1:0] row,
                                     input logic [ROW_W-1:0] col);
    return ADDR_W'(row) * ADDR_W'(MAT_DIM) + ADDR_W'(col);
  endfunction

endpackage

`default_nettype wire

[rtl/str_coef_ram.sv]
`default_nettype none

// Rotation matrix store: one write port, two registered read ports.
module str_coef_ram
  import str_pkg::*;
(
  input  wire logic     clk,
  input  wire ram_ctl_t ctl,
  output coef_t         rdata0,
  output coef_t         rdata1
);

  coef_t mem [MAT_DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[ctl.waddr] <= ctl.wdata;
    end
    rdata0 <= mem[ctl.raddr0];
    rdata1 <= mem[ctl.raddr1];
  end

endmodule

`default_nettype wire

[rtl/str_mul.sv]
`default_nettype none

// Shared signed multiplier, product registered.
module str_mul
  import str_pkg::*;
(
  input  wire logic      clk,
  input  wire mul_opnd_t op_a,
  input  wire mul_opnd_t op_b,
  output prod_t          prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

`default_nettype wire

[rtl/str_round_sat.sv]
`default_nettype none

// Round to nearest (ties up), drop SHIFT_BITS fraction bits, saturate.
module str_round_sat
  import str_pkg::*;
(
  input  wire acc_t acc,
  output tensor_t   res,
  output logic      clip
);

  localparam logic [ACC_W-1:0] HALF = {{(ACC_W-1){1'b0}}, 1'b1} << (SHIFT_BITS - 1);
  localparam int TOP_LO = SHIFT_BITS + TENSOR_WIDTH - 1;

  logic [ACC_W-1:0]      sum;
  logic [ACC_W-TOP_LO-1:0] top;
  logic                  all_one;
  logic                  all_zero;

  always_comb begin
    sum      = acc + HALF;
    top      = sum[ACC_W-1:TOP_LO];
    all_one  = &top;
    all_zero = ~|top;
    clip     = 1'b0;
    res      = sum[TOP_LO:SHIFT_BITS];
    if (sum[ACC_W-1] && !all_one) begin
      clip = 1'b1;
      res  = {1'b1, {(TENSOR_WIDTH-1){1'b0}}};
    end else if (!sum[ACC_W-1] && !all_zero) begin
      clip = 1'b1;
      res  = {1'b0, {(TENSOR_WIDTH-1){1'b1}}};
    end
  end

endmodule

`default_nettype wire

[rtl/symmetric_tensor_rotation.sv]
// Symmetric 3x3 tensor rotation, local to global: G = R T R^T.
// Input stream (s_*): one beat per item. s_tuser carries the operation and
// row index, s_tdata the six 32-bit values. A load beat (operation 0)
// writes one row of R (low 16 bits of value_0..2, Q2.14) and gives no
// result; a rotate beat (1) runs the tensor (Q16.16) through the stored R;
// a pass beat (2) returns the tensor as is. Operation 3 and loads to row 3
// are dropped.
// Output stream (m_*): one beat per rotate or pass, six saturated Q16.16
// components in m_tdata, the clip flag in m_tuser.
// Timing: a load writes one entry per cycle, then the block is idle again.
// A rotate shares one 33x33 multiplier: each term of each component fetches
// a coefficient pair, multiplies it (an off-diagonal term adds the swapped
// pair's product), scales the sum by the tensor value and accumulates; an
// add and round close each component, six in turn; a pass goes to S_OUT.
// s_tready is high only while the sequencer is idle. The result sits in an
// output register, so a new item may be accepted while it waits; if the
// receiver stalls, the next result is held until that beat is taken.
// Reset (rst, synchronous) idles the sequencer and drops m_tvalid; the
// matrix is not cleared and must be loaded before the first rotate.
`default_nettype none

module symmetric_tensor_rotation
  import str_pkg::*;
(
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  // value_0..value_5, 32 bits each, from bit 0 up
  input  wire logic [NUM_COMP*TENSOR_WIDTH-1:0] s_tdata,
  // operation [1:0], row_index [3:2]
  input  wire logic [OP_W+ROW_W-1:0]            s_tuser,
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  // out_xx, out_yy, out_zz, out_xy, out_yz, out_zx, 32 bits each, from bit 0 up
  output logic [NUM_COMP*TENSOR_WIDTH-1:0]      m_tdata,
  // saturated [0]
  output logic                                  m_tuser
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_LOAD = 4'd1;
  localparam logic [3:0] S_R1   = 4'd2;
  localparam logic [3:0] S_C1   = 4'd3;
  localparam logic [3:0] S_C2   = 4'd4;
  localparam logic [3:0] S_C3   = 4'd5;
  localparam logic [3:0] S_T    = 4'd6;
  localparam logic [3:0] S_FIN1 = 4'd7;
  localparam logic [3:0] S_FIN2 = 4'd8;
  localparam logic [3:0] S_OUT  = 4'd9;

  logic [3:0]       state;
  logic [IDX_W-1:0] o_idx;
  logic [IDX_W-1:0] i_idx;
  logic [ROW_W-1:0] ld_col;
  logic [ROW_W-1:0] row_q;
  tensor_t          tin [NUM_COMP];
  tensor_t          res [NUM_COMP];
  csum_t            c_q;
  logic             pend;
  acc_t             acc;
  logic             clip_q;

  logic             s_fire;
  logic [OP_W-1:0]  op_in;
  logic [ROW_W-1:0] row_in;
  ram_ctl_t         ram_ctl;
  coef_t            rdata0;
  coef_t            rdata1;
  mul_opnd_t        op_a;
  mul_opnd_t        op_b;
  prod_t            prod;
  acc_t             prod_ext;
  tensor_t          rnd_res;
  logic             rnd_clip;
  logic [IDX_W-1:0] o_rd;
  logic [IDX_W-1:0] i_rd;
  logic             offdiag;

  assign s_tready = (state == S_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign op_in    = s_tuser[OP_W-1:0];
  assign row_in   = s_tuser[OP_W+ROW_W-1:OP_W];
  assign offdiag  = (i_idx >= IDX_OFFD);
  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  // Which term's first coefficient pair to fetch this cycle
  always_comb begin
    o_rd = o_idx;
    i_rd = i_idx;
    case (state)
      S_T:     i_rd = i_idx + 3'd1;
      S_FIN2: begin
        o_rd = o_idx + 3'd1;
        i_rd = '0;
      end
      default: ;
    endcase
  end

  // Store port: load writes one entry per cycle; C1 fetches the
  // swapped pair for the off-diagonal term, other states the first pair.
  always_comb begin
    ram_ctl.we    = (state == S_LOAD);
    ram_ctl.waddr = mat_addr(row_q, ld_col);
    ram_ctl.wdata = tin[IDX_W'(ld_col)][COEF_WIDTH-1:0];
    if (state == S_C1) begin
      ram_ctl.raddr0 = mat_addr(pair_a(o_idx), pair_b(i_idx));
      ram_ctl.raddr1 = mat_addr(pair_b(o_idx), pair_a(i_idx));
    end else begin
      ram_ctl.raddr0 = mat_addr(pair_a(o_rd), pair_a(i_rd));
      ram_ctl.raddr1 = mat_addr(pair_b(o_rd), pair_b(i_rd));
    end
  end

  // Multiplier operands: tensor x coefficient sum in T, else coef x coef
  always_comb begin
    if (state == S_T) begin
      op_a = {{(MUL_W-TENSOR_WIDTH){tin[i_idx][TENSOR_WIDTH-1]}}, tin[i_idx]};
      op_b = mul_opnd_t'(c_q);
    end else begin
      op_a = {{(MUL_W-COEF_WIDTH){rdata0[COEF_WIDTH-1]}}, rdata0};
      op_b = {{(MUL_W-COEF_WIDTH){rdata1[COEF_WIDTH-1]}}, rdata1};
    end
  end

  str_coef_ram u_ram (
    .clk    (clk),
    .ctl    (ram_ctl),
    .rdata0 (rdata0),
    .rdata1 (rdata1)
  );

  str_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  str_round_sat u_rnd (
    .acc  (acc),
    .res  (rnd_res),
    .clip (rnd_clip)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // launch a new result beat, or retire the one just taken
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_fire) begin
            for (int n = 0; n < NUM_COMP; n++) begin
              tin[n] <= s_tdata[n*TENSOR_WIDTH +: TENSOR_WIDTH];
              res[n] <= s_tdata[n*TENSOR_WIDTH +: TENSOR_WIDTH];
            end
            row_q  <= row_in;
            ld_col <= '0;
            o_idx  <= '0;
            i_idx  <= '0;
            acc    <= '0;
            pend   <= 1'b0;
            clip_q <= 1'b0;
            case (op_in)
              OP_LOAD:   state <= (row_in <= ROW_LAST) ? S_LOAD : S_IDLE;
              OP_ROTATE: state <= S_R1;
              OP_PASS:   state <= S_OUT;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_LOAD: begin
          ld_col <= ld_col + 2'd1;
          if (ld_col == ROW_LAST) begin
            state <= S_IDLE;
          end
        end
        S_R1: begin
          state <= S_C1;
        end
        S_C1: begin
          if (pend) begin
            acc <= acc + prod_ext;
          end
          pend  <= 1'b0;
          state <= S_C2;
        end
        S_C2: begin
          c_q   <= prod[CSUM_W-1:0];
          state <= offdiag ? S_C3 : S_T;
        end
        S_C3: begin
          c_q   <= c_q + prod[CSUM_W-1:0];
          state <= S_T;
        end
        S_T: begin
          pend <= 1'b1;
          if (i_idx == IDX_LAST) begin
            state <= S_FIN1;
          end else begin
            i_idx <= i_idx + 3'd1;
            state <= S_C1;
          end
        end
        S_FIN1: begin
          acc   <= acc + prod_ext;
          pend  <= 1'b0;
          state <= S_FIN2;
        end
        S_FIN2: begin
          res[o_idx] <= rnd_res;
          clip_q     <= clip_q | rnd_clip;
          acc        <= '0;
          i_idx      <= '0;
          if (o_idx == IDX_LAST) begin
            state <= S_OUT;
          end else begin
            o_idx <= o_idx + 3'd1;
            state <= S_C1;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output payload, loaded when the result beat is launched
  always_ff @(posedge clk) begin
    if (state == S_OUT && (!m_tvalid || m_tready)) begin
      for (int n = 0; n < NUM_COMP; n++) begin
        m_tdata[n*TENSOR_WIDTH +: TENSOR_WIDTH] <= res[n];
      end
      m_tuser <= clip_q;
    end
  end

endmodule

`default_nettype wire

[test/symmetric_tensor_rotation_tb.sv]
`default_nettype none

module symmetric_tensor_rotation_tb;
  import str_pkg::*;

  // codes the package does not name
  localparam logic [OP_W-1:0]  OP_UNUSED = 2'd3;
  localparam logic [ROW_W-1:0] ROW_NONE  = 2'd3;

  localparam int RANDOM_ITEMS    = 800;
  localparam int PRESSURE_AT     = 30;     // result count that starts the long hold-off
  localparam int PRESSURE_CYCLES = 3000;
  localparam int DRAIN_CYCLES    = 200;
  localparam int CYCLE_LIMIT     = 600000;

  localparam logic signed [127:0] SAT_HI = (128'sd1 <<< (TENSOR_WIDTH - 1)) - 128'sd1;
  localparam logic signed [127:0] SAT_LO = -(128'sd1 <<< (TENSOR_WIDTH - 1));

  // component index -> axis pair (xx yy zz xy yz zx)
  localparam int AX_A [NUM_COMP] = '{0, 1, 2, 0, 1, 2};
  localparam int AX_B [NUM_COMP] = '{0, 1, 2, 1, 2, 0};
  localparam int PERM [6][3] = '{'{0, 1, 2}, '{0, 2, 1}, '{1, 0, 2},
                                 '{1, 2, 0}, '{2, 0, 1}, '{2, 1, 0}};

  typedef struct packed {
    logic [OP_W-1:0]              op;
    logic [ROW_W-1:0]             row;
    tensor_t [NUM_COMP-1:0]       val;   // val[0] = value_0 in the low bits
  } beat_in_t;

  typedef struct packed {
    tensor_t [NUM_COMP-1:0] comp;
    logic                   sat;
  } global_t;

  string comp_name [NUM_COMP] = '{"out_xx", "out_yy", "out_zz", "out_xy", "out_yz", "out_zx"};

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [NUM_COMP*TENSOR_WIDTH-1:0] s_tdata = '0;   // value_0..value_5, 32 bits each
  logic [OP_W+ROW_W-1:0]            s_tuser = '0;   // operation [1:0], row_index [3:2]
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [NUM_COMP*TENSOR_WIDTH-1:0] m_tdata;        // out_xx..out_zx, 32 bits each
  logic                             m_tuser;        // saturated

  symmetric_tensor_rotation uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  // predictor state: the rotation store as the block should hold it
  coef_t    coef_store [MAT_DEPTH];
  global_t  global_expected [$];
  beat_in_t item_pending [$];
  beat_in_t drv_item;

  int  issued = 0;     // beats put on s_* by the driver
  int  taken = 0;      // beats accepted by the block
  int  out_seen = 0;   // result beats taken from m_*
  bit  failed = 1'b0;
  int  cycles = 0;

  // G = R T R^T, exact sum, round half up, saturate
  function automatic global_t rotate_tensor(input tensor_t [NUM_COMP-1:0] t);
    global_t r;
    logic signed [127:0] acc, tv, cv;
    longint c;
    int a, b, j, k;
    r.sat = 1'b0;
    for (int o = 0; o < NUM_COMP; o++) begin
      a = AX_A[o];
      b = AX_B[o];
      acc = '0;
      for (int i = 0; i < NUM_COMP; i++) begin
        j = AX_A[i];
        k = AX_B[i];
        c = longint'(coef_store[a*3+j]) * longint'(coef_store[b*3+k]);
        // off-diagonal input counts from both sides
        if (j != k)
          c += longint'(coef_store[a*3+k]) * longint'(coef_store[b*3+j]);
        tv = signed'(t[i]);
        cv = c;
        acc = acc + tv * cv;
      end
      acc = (acc + (128'sd1 <<< (SHIFT_BITS - 1))) >>> SHIFT_BITS;
      if (acc > SAT_HI) begin
        r.comp[o] = SAT_HI[TENSOR_WIDTH-1:0];
        r.sat = 1'b1;
      end else if (acc < SAT_LO) begin
        r.comp[o] = SAT_LO[TENSOR_WIDTH-1:0];
        r.sat = 1'b1;
      end else begin
        r.comp[o] = acc[TENSOR_WIDTH-1:0];
      end
    end
    return r;
  endfunction

  // update predictor state for one accepted input beat
  task automatic apply_beat(input beat_in_t it);
    global_t r;
    case (it.op)
      OP_LOAD: begin
        // row three is dropped; only the low coefficient bits are kept
        if (it.row != ROW_NONE)
          for (int i = 0; i < MAT_DIM; i++)
            coef_store[it.row*3+i] = it.val[i][COEF_WIDTH-1:0];
      end
      OP_ROTATE: global_expected.push_back(rotate_tensor(it.val));
      OP_PASS: begin
        r.comp = it.val;
        r.sat = 1'b0;
        global_expected.push_back(r);
      end
      default: ;
    endcase
  endtask

  function automatic beat_in_t make_item(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
                                         input tensor_t v0, input tensor_t v1, input tensor_t v2,
                                         input tensor_t v3, input tensor_t v4, input tensor_t v5);
    beat_in_t it;
    it.op = op;
    it.row = row;
    it.val = {v5, v4, v3, v2, v1, v0};
    return it;
  endfunction

  function automatic tensor_t pick_value();
    case ($urandom_range(0, 9))
      0: return SAT_HI[TENSOR_WIDTH-1:0];
      1: return SAT_LO[TENSOR_WIDTH-1:0];
      2: return '0;
      3: return tensor_t'(int'($urandom_range(0, 16)) - 8);   // near rounding ties
      4, 5, 6: return tensor_t'(int'($urandom_range(0, 1 << 24)) - (1 << 23));
      default: return tensor_t'($urandom());
    endcase
  endfunction

  // 32-bit word whose low bits are the coefficient; upper bits sometimes junk
  function automatic tensor_t pick_coef();
    coef_t c;
    logic [31:0] junk;
    case ($urandom_range(0, 7))
      0: c = 16'sh7fff;
      1: c = 16'sh8000;
      2: c = '0;
      3: c = ($urandom_range(0, 1) != 0) ? 16'sd16384 : -16'sd16384;
      4: c = coef_t'($urandom());
      default: c = coef_t'(int'($urandom_range(0, 32768)) - 16384);
    endcase
    junk = ($urandom_range(0, 3) == 0) ? $urandom() : 32'd0;
    return {junk[TENSOR_WIDTH-COEF_WIDTH-1:0], c};
  endfunction

  // signed permutation scaled to 1.0 in Q2.14: an exact rotation/reflection
  task automatic push_perm_matrix();
    int p;
    tensor_t rowv [3];
    p = $urandom_range(0, 5);
    for (int r = 0; r < MAT_DIM; r++) begin
      for (int i = 0; i < 3; i++) rowv[i] = '0;
      rowv[PERM[p][r]] = ($urandom_range(0, 1) != 0) ? 32'sd16384 : -32'sd16384;
      item_pending.push_back(make_item(OP_LOAD, ROW_W'(r), rowv[0], rowv[1], rowv[2],
                                       tensor_t'($urandom()), tensor_t'($urandom()),
                                       tensor_t'($urandom())));
    end
  endtask

  task automatic build_stimulus();
    beat_in_t it;
    int count, sel;
    tensor_t mx, mn;
    mx = SAT_HI[TENSOR_WIDTH-1:0];
    mn = SAT_LO[TENSOR_WIDTH-1:0];
    // identity, first row with junk in the upper bits of each word
    item_pending.push_back(make_item(OP_LOAD, 2'd0, 32'hFFFF_4000, 32'h1234_0000, 32'h8000_0000,
                                     32'hFFFF_FFFF, 32'h0, 32'h5A5A_A5A5));
    item_pending.push_back(make_item(OP_LOAD, 2'd1, 0, 16384, 0, 0, 0, 0));
    item_pending.push_back(make_item(OP_LOAD, ROW_LAST, 0, 0, 16384, 0, 0, 0));
    item_pending.push_back(make_item(OP_ROTATE, 2'd0, mx, mx, mx, mx, mx, mx));
    item_pending.push_back(make_item(OP_ROTATE, 2'd0, mn, mn, mn, mn, mn, mn));
    item_pending.push_back(make_item(OP_ROTATE, 2'd0, 0, 0, 0, 0, 0, 0));
    item_pending.push_back(make_item(OP_PASS, 2'd0, mx, mn, 0, -1, 1, mx));
    // row three load and operation three: both dropped
    item_pending.push_back(make_item(OP_LOAD, ROW_NONE, 32'h7FFF_7FFF, 32'h8000_8000, -1,
                                     -1, -1, -1));
    item_pending.push_back(make_item(OP_UNUSED, ROW_NONE, -1, -1, -1, -1, -1, -1));
    item_pending.push_back(make_item(OP_ROTATE, 2'd0, 100, -200, 300, -400, 500, -600));
    // half identity: diagonal gain 1/4 exercises the round-half-up ties
    item_pending.push_back(make_item(OP_LOAD, 2'd0, 8192, 0, 0, 0, 0, 0));
    item_pending.push_back(make_item(OP_LOAD, 2'd1, 0, 8192, 0, 0, 0, 0));
    item_pending.push_back(make_item(OP_LOAD, ROW_LAST, 0, 0, 8192, 0, 0, 0));
    item_pending.push_back(make_item(OP_ROTATE, 2'd0, 2, -2, 6, -6, 1, -1));
    // extreme coefficients, -2.0 and just under 2.0: saturation both ways
    item_pending.push_back(make_item(OP_LOAD, 2'd0, 32'h8000, 32'h8000, 32'h8000, 0, 0, 0));
    item_pending.push_back(make_item(OP_LOAD, 2'd1, 32'h7FFF, 32'h7FFF, 32'h7FFF, 0, 0, 0));
    item_pending.push_back(make_item(OP_LOAD, ROW_LAST, 32'h8000, 32'h7FFF, 0, 0, 0, 0));
    item_pending.push_back(make_item(OP_ROTATE, 2'd0, mx, mx, mx, mx, mx, mx));
    item_pending.push_back(make_item(OP_ROTATE, 2'd0, mn, mx, mn, mx, mn, mx));
    // 90 degrees about z
    item_pending.push_back(make_item(OP_LOAD, 2'd0, 0, 16384, 0, 0, 0, 0));
    item_pending.push_back(make_item(OP_LOAD, 2'd1, -16384, 0, 0, 0, 0, 0));
    item_pending.push_back(make_item(OP_LOAD, ROW_LAST, 0, 0, 16384, 0, 0, 0));
    item_pending.push_back(make_item(OP_ROTATE, 2'd0, 65536, -131072, 196608, 32768, -7, 12345));
    item_pending.push_back(make_item(OP_PASS, ROW_NONE, mn, mn, mn, mn, mn, mn));
    item_pending.push_back(make_item(OP_PASS, 2'd1, mx, mx, mx, mx, mx, mx));

    // random part: mostly rotates and passes under freshly loaded matrices
    count = 0;
    while (count < RANDOM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        if ($urandom_range(0, 1) != 0) begin
          push_perm_matrix();
        end else begin
          for (int r = 0; r < MAT_DIM; r++)
            item_pending.push_back(make_item(OP_LOAD, ROW_W'(r), pick_coef(), pick_coef(),
                                             pick_coef(), tensor_t'($urandom()),
                                             tensor_t'($urandom()), tensor_t'($urandom())));
        end
        count += MAT_DIM;
      end else begin
        it.row = ROW_W'($urandom());
        for (int i = 0; i < NUM_COMP; i++) it.val[i] = pick_value();
        if (sel < 14) begin
          it.op = OP_LOAD;
          it.row = ($urandom_range(0, 7) == 0) ? ROW_NONE : ROW_W'($urandom_range(0, 2));
          for (int i = 0; i < MAT_DIM; i++) it.val[i] = pick_coef();
        end else if (sel < 66) begin
          it.op = OP_ROTATE;
        end else if (sel < 93) begin
          it.op = OP_PASS;
        end else begin
          it.op = OP_UNUSED;
        end
        if (!(it.op == OP_UNUSED || (it.op == OP_LOAD && it.row == ROW_NONE)))
          count++;
        item_pending.push_back(it);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents beats at the falling edge. A new beat goes out only once
  // the previous one was taken (taken == issued); each beat draws the gap that
  // follows it, except in calm stretches where beats go back to back.
  // ---------------------------------------------------------------------------
  int gap_left = 0;
  bit drv_calm = 1'b0;

  always @(negedge clk) begin
    if (!rst && taken == issued) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (item_pending.size() != 0) begin
        drv_item = item_pending.pop_front();
        s_tdata  <= drv_item.val;
        s_tuser  <= {drv_item.row, drv_item.op};
        s_tvalid <= 1'b1;
        issued++;
        if (issued % 64 == 0) drv_calm = ($urandom_range(0, 3) == 0);
        gap_left = drv_calm ? 0 : $urandom_range(0, 11);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: m_tready also moves at the falling edge. After each result beat
  // it draws a stall; once, it holds off for a long stretch so the output
  // register fills and s_tready stays low while the driver keeps offering.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  int out_noted = 0;
  bit rcv_calm = 1'b0;

  always @(negedge clk) begin
    if (!rst) begin
      if (out_seen != out_noted) begin
        out_noted = out_seen;
        if (out_noted % 50 == 0) rcv_calm = ($urandom_range(0, 3) == 0);
        stall_left = rcv_calm ? 0 : $urandom_range(0, 11);
        if (out_noted == PRESSURE_AT) stall_left = PRESSURE_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Rising edge: check the result beat against the oldest expectation, then
  // run the predictor on the accepted input beat. Output is checked first;
  // a result can never belong to a beat accepted at the same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    global_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        out_seen++;
        if (global_expected.size() == 0) begin
          $error("result beat with no expectation pending");
          failed = 1'b1;
        end else begin
          want = global_expected.pop_front();
          for (int i = 0; i < NUM_COMP; i++) begin
            if (m_tdata[i*TENSOR_WIDTH +: TENSOR_WIDTH] !== want.comp[i]) begin
              $error("%s expected %0d actual %0d", comp_name[i], $signed(want.comp[i]),
                     $signed(m_tdata[i*TENSOR_WIDTH +: TENSOR_WIDTH]));
              failed = 1'b1;
            end
          end
          if (m_tuser !== want.sat) begin
            $error("saturated expected %0b actual %0b", want.sat, m_tuser);
            failed = 1'b1;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        apply_beat(drv_item);
        taken++;
      end
    end
  end

  // hard limit on run length
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("symmetric_tensor_rotation regression: fail");
    $finish;
  end

  initial begin
    for (int i = 0; i < MAT_DEPTH; i++) coef_store[i] = '0;
    build_stimulus();
    // single reset at the start, released at a falling edge
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // all beats accepted, then all results back, then let the sequencer settle
    while (item_pending.size() != 0 || taken != issued) @(negedge clk);
    while (global_expected.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (!failed && global_expected.size() == 0) begin
      $display("symmetric_tensor_rotation regression: pass");
    end else begin
      $display("symmetric_tensor_rotation regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

[symmetric_tensor_rotation.f]
rtl/str_pkg.sv
rtl/str_coef_ram.sv
rtl/str_mul.sv
rtl/str_round_sat.sv
rtl/symmetric_tensor_rotation.sv
test/symmetric_tensor_rotation_tb.sv
